/* sv/tsq_pkg.sv */
package tsq_pkg;

   // Depth of each of the two stacks, and the widths that follow from it.
   localparam int STACK_DEPTH = 128;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   localparam int WORD_W = 32;
   localparam int CMD_W  = 2;

   // Operation codes carried on the request tuser.
   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic push_wr;      // write the request word on top of the inbound stack
      logic xfer_rd;      // read the inbound top and schedule its move outbound
      logic out_rd;       // read the outbound top into the read register
      logic out_dec;      // remove the outbound top (pop)
      logic rsp_load;     // load the result register
      logic rsp_from_mem; // result carries the outbound read data
      logic rsp_accepted; // result reports a stored push
   } tsq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_zero;
      logic in_one;
      logic in_full;
      logic out_zero;
   } tsq_stat_type;

endpackage

/* sv/tsq_ctrl.sv */
module tsq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [tsq_pkg::CMD_W-1:0] req_command,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  tsq_pkg::tsq_stat_type     stat,
   output tsq_pkg::tsq_cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_XFER  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       is_pop_ff, is_pop_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      is_pop_in = is_pop_ff;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  tsq_pkg::CMD_PUSH: begin
                     cmd.push_wr      = !stat.in_full;
                     cmd.rsp_accepted = !stat.in_full;
                     cmd.rsp_load     = 1'b1;
                  end
                  tsq_pkg::CMD_POP, tsq_pkg::CMD_PEEK: begin
                     is_pop_in = (req_command == tsq_pkg::CMD_POP);
                     if (!stat.out_zero) begin
                        state_in = ST_READ;
                     end else if (!stat.in_zero) begin
                        state_in = ST_XFER;
                     end else begin
                        cmd.rsp_load = 1'b1;
                     end
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_XFER: begin
            cmd.xfer_rd = 1'b1;
            if (stat.in_one) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.out_rd  = 1'b1;
            cmd.out_dec = is_pop_ff;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               cmd.rsp_load     = 1'b1;
               cmd.rsp_from_mem = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         is_pop_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         is_pop_ff    <= is_pop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result is never written over one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> out_free)
      else $error("result register overwritten");

   // A transfer step only runs while the inbound stack still holds an entry.
   a_xfer_has_entry: assert property (@(posedge clock) disable iff (reset)
      cmd.xfer_rd |-> !stat.in_zero)
      else $error("transfer from empty inbound stack");

endmodule

/* sv/tsq_dp.sv */
module tsq_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  tsq_pkg::tsq_cmd_type       cmd,
   input  logic [tsq_pkg::WORD_W-1:0] data_in,
   output tsq_pkg::tsq_stat_type      stat,
   output logic [tsq_pkg::WORD_W-1:0] data_out,
   output logic                       data_valid,
   output logic                       push_accepted,
   output logic                       queue_empty
);

   logic [tsq_pkg::WORD_W-1:0] in_mem  [tsq_pkg::STACK_DEPTH];
   logic [tsq_pkg::WORD_W-1:0] out_mem [tsq_pkg::STACK_DEPTH];

   logic [tsq_pkg::CNT_W-1:0]  in_cnt_ff, in_cnt_in;
   logic [tsq_pkg::CNT_W-1:0]  out_cnt_ff, out_cnt_in;
   logic [tsq_pkg::CNT_W-1:0]  in_cnt_dec, out_cnt_dec;
   logic                       xfer_pend_ff;
   logic [tsq_pkg::WORD_W-1:0] in_rd_ff;
   logic [tsq_pkg::WORD_W-1:0] out_rd_ff;

   logic [tsq_pkg::WORD_W-1:0] data_out_ff;
   logic                       data_valid_ff;
   logic                       push_accepted_ff;
   logic                       queue_empty_ff;

   assign in_cnt_dec  = in_cnt_ff - tsq_pkg::CNT_W'(1);
   assign out_cnt_dec = out_cnt_ff - tsq_pkg::CNT_W'(1);

   always_comb begin
      in_cnt_in = in_cnt_ff;
      if (cmd.push_wr) begin
         in_cnt_in = in_cnt_ff + tsq_pkg::CNT_W'(1);
      end else if (cmd.xfer_rd) begin
         in_cnt_in = in_cnt_dec;
      end
   end

   // The write of a moved entry lands in the cycle after its read was issued.
   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (xfer_pend_ff) begin
         out_cnt_in = out_cnt_ff + tsq_pkg::CNT_W'(1);
      end else if (cmd.out_dec) begin
         out_cnt_in = out_cnt_dec;
      end
   end

   assign stat.in_zero  = (in_cnt_ff == '0);
   assign stat.in_one   = (in_cnt_ff == tsq_pkg::CNT_W'(1));
   assign stat.in_full  = (in_cnt_ff == tsq_pkg::CNT_W'(tsq_pkg::STACK_DEPTH));
   assign stat.out_zero = (out_cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.push_wr) begin
         in_mem[in_cnt_ff[tsq_pkg::PTR_W-1:0]] <= data_in;
      end
      if (cmd.xfer_rd) begin
         in_rd_ff <= in_mem[in_cnt_dec[tsq_pkg::PTR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (xfer_pend_ff) begin
         out_mem[out_cnt_ff[tsq_pkg::PTR_W-1:0]] <= in_rd_ff;
      end
      if (cmd.out_rd) begin
         out_rd_ff <= out_mem[out_cnt_dec[tsq_pkg::PTR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         xfer_pend_ff <= 1'b0;
      end else begin
         in_cnt_ff    <= in_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         xfer_pend_ff <= cmd.xfer_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         data_out_ff      <= cmd.rsp_from_mem ? out_rd_ff : '0;
         data_valid_ff    <= cmd.rsp_from_mem;
         push_accepted_ff <= cmd.rsp_accepted;
         queue_empty_ff   <= (in_cnt_in == '0) && (out_cnt_in == '0);
      end
   end

   assign data_out      = data_out_ff;
   assign data_valid    = data_valid_ff;
   assign push_accepted = push_accepted_ff;
   assign queue_empty   = queue_empty_ff;

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push_wr |-> !stat.in_full)
      else $error("push written into a full inbound stack");

   a_read_has_entry: assert property (@(posedge clock) disable iff (reset)
      cmd.out_rd |-> (!stat.out_zero && !xfer_pend_ff))
      else $error("outbound read with no settled entry");

endmodule

/* sv/two_stack_queue.sv */
// A push, or an unused command, gives its result in the cycle after it is accepted.
// A pop or peek that finds the outbound stack filled goes through the read and result states.
// One that must move N inbound entries first runs N transfer steps and a drain step.
// Items go one at a time; the transfer moves one entry per cycle through the memories.
// Reset is synchronous and active high: counts, controller and result valid clear;
// stack contents are not cleared and are never read before being written.
module two_stack_queue (
   input  logic                       clock,
   input  logic                       reset,
   // Request channel.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [tsq_pkg::WORD_W-1:0] req_tdata,  // [31:0] data_in
   input  logic [tsq_pkg::CMD_W-1:0]  req_tuser,  // [1:0] command
   // Result channel.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [tsq_pkg::WORD_W-1:0] rsp_tdata,  // [31:0] data_out
   output logic [2:0]                 rsp_tuser   // [0] data_valid, [1] push_accepted,
                                                  // [2] queue_empty
);

   // The controller walks each item through its steps; the datapath holds the
   // two stack memories, their counts and the result register. A pop or peek
   // on an empty outbound stack first moves the inbound entries across, top
   // first, which turns the order round so the oldest word lands on top.

   tsq_pkg::tsq_cmd_type  cmd;
   tsq_pkg::tsq_stat_type stat;

   tsq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .stat        (stat),
      .cmd         (cmd)
   );

   tsq_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .data_in       (req_tdata),
      .stat          (stat),
      .data_out      (rsp_tdata),
      .data_valid    (rsp_tuser[0]),
      .push_accepted (rsp_tuser[1]),
      .queue_empty   (rsp_tuser[2])
   );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   // Cycles without any accepted item, on either side, before the run is declared hung.
   // The slowest legitimate pause is the long receiver hold-off (HOLD_CYCLES) plus a full
   // transfer of the inbound stack, so this leaves a wide margin.
   localparam int IDLE_LIMIT   = 5000;
   localparam int HOLD_CYCLES  = 400;
   localparam int PRESSURE_AT  = 1000;
   localparam int DRAIN_CYCLES = 2 * tsq_pkg::STACK_DEPTH + 20;

   // One result item as the block reports it.
   typedef struct packed {
      logic [tsq_pkg::WORD_W-1:0] word;   // data_out
      logic                       found;  // data_valid
      logic                       stored; // push_accepted
      logic                       empty;  // queue_empty
   } queue_result_type;

   // One row of stimulus; where typed is set, want holds the result written out by hand.
   typedef struct packed {
      logic [tsq_pkg::CMD_W-1:0]  cmd;
      logic [tsq_pkg::WORD_W-1:0] data;
      logic                       typed;
      queue_result_type           want;
   } stim_row_type;

   localparam queue_result_type RESULT_EMPTY  = '{32'h0, 1'b0, 1'b0, 1'b1};
   localparam queue_result_type RESULT_STORED = '{32'h0, 1'b0, 1'b1, 1'b0};
   localparam queue_result_type RESULT_IDLE   = '{32'h0, 1'b0, 1'b0, 1'b0};
   localparam queue_result_type UNTYPED       = '{32'h0, 1'b0, 1'b0, 1'b0};

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [tsq_pkg::WORD_W-1:0] req_tdata;  // [31:0] data_in
   logic [tsq_pkg::CMD_W-1:0]  req_tuser;  // [1:0] command
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [tsq_pkg::WORD_W-1:0] rsp_tdata;  // [31:0] data_out
   logic [2:0]                 rsp_tuser;  // [0] data_valid, [1] push_accepted, [2] queue_empty

   two_stack_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Stimulus, the results still owed by the block, and the run's bookkeeping.
   stim_row_type     stim_q[$];
   queue_result_type pending_results[$];
   int               accepted_requests = 0;
   int               mismatch_count    = 0;
   bit               sender_done       = 1'b0;

   // The testbench's own copy of the two stacks. Both counts start at zero; the
   // contents need no reset because nothing is read above a count.
   logic [tsq_pkg::WORD_W-1:0] shadow_inbound  [tsq_pkg::STACK_DEPTH];
   logic [tsq_pkg::WORD_W-1:0] shadow_outbound [tsq_pkg::STACK_DEPTH];
   logic [tsq_pkg::CNT_W-1:0]  shadow_in_count  = '0;
   logic [tsq_pkg::CNT_W-1:0]  shadow_out_count = '0;

   // Directed rows. The first few are typed by hand: an empty queue straight after reset,
   // the four extreme words, the unused command, and the first transfer, which must hand
   // back the oldest word. Most of the rest lean on the predictor.
   stim_row_type directed_rows [0:22] = '{
      '{tsq_pkg::CMD_POP,  32'h0000_0000, 1'b1, RESULT_EMPTY},
      '{tsq_pkg::CMD_PEEK, 32'hFFFF_FFFF, 1'b1, RESULT_EMPTY},
      '{tsq_pkg::CMD_NOP,  32'h0000_0000, 1'b1, RESULT_EMPTY},
      '{tsq_pkg::CMD_PUSH, 32'h8000_0000, 1'b1, RESULT_STORED},
      '{tsq_pkg::CMD_PUSH, 32'h7FFF_FFFF, 1'b1, RESULT_STORED},
      '{tsq_pkg::CMD_PUSH, 32'hFFFF_FFFF, 1'b1, RESULT_STORED},
      '{tsq_pkg::CMD_PUSH, 32'h0000_0000, 1'b1, RESULT_STORED},
      '{tsq_pkg::CMD_NOP,  32'hFFFF_FFFF, 1'b1, RESULT_IDLE},
      '{tsq_pkg::CMD_PEEK, 32'h0000_0000, 1'b1, '{32'h8000_0000, 1'b1, 1'b0, 1'b0}},
      '{tsq_pkg::CMD_POP,  32'h0000_0000, 1'b1, '{32'h8000_0000, 1'b1, 1'b0, 1'b0}},
      '{tsq_pkg::CMD_PUSH, 32'hAAAA_AAAA, 1'b0, UNTYPED},
      '{tsq_pkg::CMD_POP,  32'h5555_5555, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0}},
      '{tsq_pkg::CMD_PEEK, 32'h0000_0000, 1'b0, UNTYPED},
      '{tsq_pkg::CMD_POP,  32'h0000_0000, 1'b0, UNTYPED},
      '{tsq_pkg::CMD_POP,  32'h0000_0000, 1'b0, UNTYPED},
      '{tsq_pkg::CMD_POP,  32'h0000_0000, 1'b0, UNTYPED},
      '{tsq_pkg::CMD_POP,  32'h0000_0000, 1'b1, RESULT_EMPTY},
      '{tsq_pkg::CMD_PUSH, 32'h5555_5555, 1'b0, UNTYPED},
      '{tsq_pkg::CMD_PUSH, 32'h1234_5678, 1'b0, UNTYPED},
      '{tsq_pkg::CMD_NOP,  32'h8000_0000, 1'b0, UNTYPED},
      '{tsq_pkg::CMD_POP,  32'h0000_0000, 1'b0, UNTYPED},
      '{tsq_pkg::CMD_PEEK, 32'h0000_0000, 1'b0, UNTYPED},
      '{tsq_pkg::CMD_POP,  32'h0000_0000, 1'b0, UNTYPED}
   };

   // Works out the result of one command and moves the shadow stacks on. A pop or peek
   // that finds the outbound stack empty first moves the whole inbound stack across,
   // top first, so the oldest word ends up on the outbound top.
   function automatic queue_result_type predict_queue_result(
      input logic [tsq_pkg::CMD_W-1:0]  op,
      input logic [tsq_pkg::WORD_W-1:0] word);
      queue_result_type          res;
      logic [tsq_pkg::CNT_W-1:0] top;
      res = '0;
      case (op)
         tsq_pkg::CMD_PUSH: begin
            if (shadow_in_count < tsq_pkg::STACK_DEPTH) begin
               shadow_inbound[shadow_in_count[tsq_pkg::PTR_W-1:0]] = word;
               shadow_in_count = shadow_in_count + 1'b1;
               res.stored = 1'b1;
            end
         end
         tsq_pkg::CMD_POP, tsq_pkg::CMD_PEEK: begin
            if (shadow_out_count == 0) begin
               while (shadow_in_count != 0 && shadow_out_count < tsq_pkg::STACK_DEPTH) begin
                  shadow_in_count = shadow_in_count - 1'b1;
                  shadow_outbound[shadow_out_count[tsq_pkg::PTR_W-1:0]] =
                     shadow_inbound[shadow_in_count[tsq_pkg::PTR_W-1:0]];
                  shadow_out_count = shadow_out_count + 1'b1;
               end
            end
            if (shadow_out_count != 0) begin
               top       = shadow_out_count - 1'b1;
               res.word  = shadow_outbound[top[tsq_pkg::PTR_W-1:0]];
               res.found = 1'b1;
               if (op == tsq_pkg::CMD_POP)
                  shadow_out_count = top;
            end
         end
         default: begin
            // The unused command leaves everything as it was.
         end
      endcase
      res.empty = (shadow_in_count == 0) && (shadow_out_count == 0);
      return res;
   endfunction

   // Half the words are random; the rest are the extremes and single set bits.
   function automatic logic [tsq_pkg::WORD_W-1:0] random_word();
      logic [tsq_pkg::WORD_W-1:0] w;
      case ($urandom_range(0, 9))
         0:       w = 32'h8000_0000;
         1:       w = 32'h7FFF_FFFF;
         2:       w = 32'hFFFF_FFFF;
         3:       w = 32'h0000_0000;
         4:       w = 32'h1 << $urandom_range(0, 31);
         default: w = $urandom;
      endcase
      return w;
   endfunction

   // Picks a command by weight.
   function automatic logic [tsq_pkg::CMD_W-1:0] pick_command(input int push_w,
                                                              input int pop_w,
                                                              input int peek_w,
                                                              input int nop_w);
      int r;
      r = $urandom_range(0, push_w + pop_w + peek_w + nop_w - 1);
      if (r < push_w)
         return tsq_pkg::CMD_PUSH;
      else if (r < push_w + pop_w)
         return tsq_pkg::CMD_POP;
      else if (r < push_w + pop_w + peek_w)
         return tsq_pkg::CMD_PEEK;
      return tsq_pkg::CMD_NOP;
   endfunction

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input logic [tsq_pkg::WORD_W-1:0] got,
                                  input logic [tsq_pkg::WORD_W-1:0] want);
      mismatch_count++;
      $display("ERROR at %0t ns: %s got %h, want %h", $time, what, got, want);
   endtask

   // Free-running clock with a 4 ns period.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Sender. The stimulus is built first: the directed table, then a balanced mix, then
   // two passes that overfill the inbound stack (so that pushes are dropped), each followed
   // by a peek that may set off a full transfer, then a pop-heavy stretch that drains the
   // queue and runs past empty, and last a series of chunks with random weights so that
   // the occupancy wanders up and down. Items go out in bursts with random gaps between.
   initial begin : sender
      int i;
      int n;
      int burst_left;
      int gap;
      int push_w;
      int pop_w;
      int peek_w;
      int nop_w;

      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = tsq_pkg::CMD_PUSH;

      for (i = 0; i < 23; i++)
         stim_q.push_back(directed_rows[i]);
      for (i = 0; i < 400; i++)
         stim_q.push_back(stim_row_type'{pick_command(45, 35, 15, 5), random_word(), 1'b0,
                                         UNTYPED});
      for (n = 0; n < 2; n++) begin
         for (i = 0; i < tsq_pkg::STACK_DEPTH + 7; i++)
            stim_q.push_back(stim_row_type'{tsq_pkg::CMD_PUSH, random_word(), 1'b0,
                                            UNTYPED});
         stim_q.push_back(stim_row_type'{tsq_pkg::CMD_PEEK, random_word(), 1'b0, UNTYPED});
      end
      for (i = 0; i < 300; i++)
         stim_q.push_back(stim_row_type'{pick_command(0, 90, 10, 0), random_word(), 1'b0,
                                         UNTYPED});
      for (n = 0; n < 22; n++) begin
         push_w = $urandom_range(10, 70);
         pop_w  = $urandom_range(10, 60);
         peek_w = $urandom_range(0, 25);
         nop_w  = $urandom_range(0, 8);
         for (i = 0; i < 40; i++)
            stim_q.push_back(stim_row_type'{pick_command(push_w, pop_w, peek_w, nop_w),
                                            random_word(), 1'b0, UNTYPED});
      end

      @(negedge clock);
      while (reset)
         @(negedge clock);

      burst_left = 0;
      for (i = 0; i < stim_q.size(); i++) begin
         if (burst_left == 0) begin
            // Now and then a long burst with no idling at all.
            burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 24);
            gap        = $urandom_range(0, 12);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         req_tvalid <= 1'b1;
         req_tdata  <= stim_q[i].data;
         req_tuser  <= stim_q[i].cmd;
         burst_left--;
         @(posedge clock);
         while (!req_tready)
            @(posedge clock);
         @(negedge clock);
      end
      req_tvalid  <= 1'b0;
      sender_done = 1'b1;
   end

   // Receiver. It switches between patterns of its own: always ready, mostly ready,
   // mostly stalled, and a regular on-off rhythm. Once, well into the run, it
   // holds off for a long stretch while the sender keeps offering items, so the block
   // fills up and stalls its input.
   initial begin : receiver
      int  mode;
      int  span;
      int  cyc;
      bit  held_off;
      bit  ready_next;

      rsp_tready = 1'b0;
      held_off   = 1'b0;
      cyc        = 0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 96);
         repeat (span) begin
            if (!held_off && accepted_requests >= PRESSURE_AT) begin
               held_off = 1'b1;
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
            end
            case (mode)
               0:       ready_next = 1'b1;
               1:       ready_next = ($urandom_range(0, 3) != 0);
               2:       ready_next = ($urandom_range(0, 9) < 3);
               default: ready_next = cyc[1];
            endcase
            rsp_tready <= ready_next;
            @(negedge clock);
            cyc++;
         end
      end
   end

   // Scoreboard. A result accepted at this edge is checked against the oldest result
   // still owed; a request accepted at the same edge cannot be answered before the next
   // one, so results are handled first.
   always @(posedge clock) begin : scoreboard
      queue_result_type want;
      queue_result_type predicted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result item with nothing pending", rsp_tdata, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata !== want.word)
                  report_mismatch("data_out", rsp_tdata, want.word);
               if (rsp_tuser[0] !== want.found)
                  report_mismatch("data_valid", {31'b0, rsp_tuser[0]}, {31'b0, want.found});
               if (rsp_tuser[1] !== want.stored)
                  report_mismatch("push_accepted", {31'b0, rsp_tuser[1]},
                                  {31'b0, want.stored});
               if (rsp_tuser[2] !== want.empty)
                  report_mismatch("queue_empty", {31'b0, rsp_tuser[2]}, {31'b0, want.empty});
            end
         end
         if (req_tvalid && req_tready) begin
            // The predictor runs on every item so that its stacks stay in step, even
            // where the row carries a result typed by hand.
            predicted = predict_queue_result(req_tuser, req_tdata);
            if (stim_q[accepted_requests].typed)
               pending_results.push_back(stim_q[accepted_requests].want);
            else
               pending_results.push_back(predicted);
            accepted_requests++;
         end
      end
   end

   // Watchdog: ends the run if nothing is accepted on either side for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Reset first, then wait until every item has gone in and every owed
   // result has come back, let the block drain for DRAIN_CYCLES, and give the verdict.
   initial begin : run_control
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (!sender_done)
         @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* files.f */
sv/tsq_pkg.sv
sv/tsq_ctrl.sv
sv/tsq_dp.sv
sv/two_stack_queue.sv
verif/testbench.sv
